// ===== sv/bfm3_pkg.sv =====
`timescale 1ns / 1ps
package bfm3_pkg;

  localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2     = 32'h1b873593;
  localparam logic [31:0] MM_ADD    = 32'he6546b64;
  localparam logic [31:0] MM_F1     = 32'h85ebca6b;
  localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
  localparam logic [31:0] SEED_STEP = 32'hfba4c795;

  // modulus is at most 8 * 65535
  localparam int MOD_W = 20;

  localparam logic [1:0] REG_TWEAK        = 2'd0;
  localparam logic [1:0] REG_HASH_COUNT   = 2'd1;
  localparam logic [1:0] REG_FILTER_BYTES = 2'd2;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_last;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  hash_number;
    logic [18:0] bit_index;
    logic [7:0]  filter_byte;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SC1,
    ST_SC2,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_FIN_RD,
    ST_FIN_M1,
    ST_FIN_M2,
    ST_DIV,
    ST_BYTE_RD,
    ST_BYTE_WR,
    ST_OUT
  } state_t;

endpackage

// ===== sv/bfm3_rem.sv =====
`timescale 1ns / 1ps
module bfm3_rem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                dividend,
  input  logic [bfm3_pkg::MOD_W-1:0] modulus,
  output logic                       done,
  output logic [bfm3_pkg::MOD_W-1:0] rem
);
  import bfm3_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] num;
  logic [MOD_W:0] trial;

  // restoring remainder, one dividend bit a cycle
  assign trial = {rem, num[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (busy) begin
      num <= {num[30:0], 1'b0};
      if (trial >= {1'b0, modulus}) begin
        rem <= MOD_W'(trial - {1'b0, modulus});
      end else begin
        rem <= trial[MOD_W-1:0];
      end
    end
  end

endmodule

// ===== sv/bloom_filter_murmur3_insert.sv =====
`timescale 1ns / 1ps
// Bloom filter insert with MurmurHash3 x86 32-bit lanes. Key bytes are taken one beat at a
// time; a byte that neither finishes a 4-byte block nor ends the key is only stored. Any other
// byte is scrambled with two multiplies on the shared multiplier; one that finishes a block is
// then mixed into all MAX_HASH_FUNCS lanes (a read and a write of the lane memory each). The
// last byte of a key then runs, per hash function, a lane read, two finalizer multiplies, a
// 32-step bit-serial remainder and a read-modify-write of the filter byte, and waits out any
// output stall.
// After reset a clearing pass writes zero to every filter byte, one a cycle; during the pass
// no key byte is taken. Configuration writes are always taken.
module bloom_filter_murmur3_insert #(
  parameter int MAX_FILTER_BYTES = 36000,
  parameter int MAX_HASH_FUNCS   = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bfm3_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bfm3_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import bfm3_pkg::*;

  localparam int FA_W = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
  localparam int LA_W = (MAX_HASH_FUNCS > 1) ? $clog2(MAX_HASH_FUNCS) : 1;
  localparam int LC_W = $clog2(MAX_HASH_FUNCS + 1);

  state_t state, state_next;

  logic [31:0] tweak;
  logic [5:0]  hash_count;
  logic [15:0] filter_bytes;

  logic [31:0] tweak_lat;
  logic [31:0] key_length;
  logic [31:0] pend;
  logic [31:0] acc;
  logic [31:0] kscr;
  logic [31:0] seed_run;
  logic        fresh;
  logic        do_fin;
  logic        tail_en;
  logic [LC_W-1:0] lane_cnt;
  logic [FA_W-1:0] clr_addr;
  logic [7:0]  new_byte;

  logic [31:0] lane_mem [MAX_HASH_FUNCS];
  logic [31:0] lane_rdata;
  logic        lane_we;
  logic [31:0] lane_wdata;
  logic [7:0]  filt_mem [MAX_FILTER_BYTES];
  logic [7:0]  filt_rdata;
  logic        filt_we;
  logic [FA_W-1:0] filt_waddr;
  logic [7:0]  filt_wdata;
  logic [FA_W-1:0] byte_addr;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] lane_val, mix_h, mix_r, fin_h;
  logic        accept;
  logic [1:0]  pos;
  logic [31:0] pend_new;
  logic [LC_W-1:0] n_hash;
  logic [16:0] fb_clamp;
  logic [MOD_W-1:0] modulus;
  logic        rem_start, rem_done;
  logic [MOD_W-1:0] rem_val;
  logic        slot_free;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign pos       = key_length[1:0];
  assign pend_new  = ((key_length == 32'd0) ? 32'd0 : pend)
                     | ({24'd0, in_data.key_byte} << {pos, 3'b000});

  assign n_hash = ({1'b0, hash_count} > 7'(MAX_HASH_FUNCS)) ? LC_W'(MAX_HASH_FUNCS)
                                                             : LC_W'(hash_count);
  always_comb begin
    if (filter_bytes == 16'd0) begin
      fb_clamp = 17'd1;
    end else if ({1'b0, filter_bytes} > 17'(MAX_FILTER_BYTES)) begin
      fb_clamp = 17'(MAX_FILTER_BYTES);
    end else begin
      fb_clamp = {1'b0, filter_bytes};
    end
  end
  assign modulus = {fb_clamp, 3'b000};

  assign lane_val  = fresh ? seed_run : lane_rdata;
  assign mix_h     = lane_val ^ kscr;
  assign mix_r     = {mix_h[18:0], mix_h[31:19]};
  assign lane_wdata = {mix_r[29:0], 2'b00} + mix_r + MM_ADD;
  assign fin_h     = lane_val ^ (tail_en ? kscr : 32'd0) ^ key_length;
  assign byte_addr = rem_val[FA_W+2:3];
  assign slot_free = !out_valid || !out_stall;

  // single shared multiplier, operands picked by the sequencer
  assign prod = mul_a * mul_b;

  always_comb begin
    mul_a = pend;
    mul_b = MM_C1;
    case (state)
      ST_SC2: begin
        mul_a = {acc[16:0], acc[31:17]};
        mul_b = MM_C2;
      end
      ST_FIN_M1: begin
        mul_a = fin_h ^ (fin_h >> 16);
        mul_b = MM_F1;
      end
      ST_FIN_M2: begin
        mul_a = acc ^ (acc >> 13);
        mul_b = MM_F2;
      end
      default: begin
        mul_a = pend;
        mul_b = MM_C1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    lane_we    = 1'b0;
    filt_we    = 1'b0;
    filt_waddr = byte_addr;
    filt_wdata = new_byte;
    rem_start  = 1'b0;
    case (state)
      ST_CLEAR: begin
        filt_we    = 1'b1;
        filt_waddr = clr_addr;
        filt_wdata = 8'd0;
        if (clr_addr == FA_W'(MAX_FILTER_BYTES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (pos == 2'd3 || in_data.key_last)) state_next = ST_SC1;
      end
      ST_SC1: state_next = ST_SC2;
      ST_SC2: begin
        if (tail_en) begin
          state_next = (n_hash == '0) ? ST_IDLE : ST_FIN_RD;
        end else begin
          state_next = ST_MIX_RD;
        end
      end
      ST_MIX_RD: state_next = ST_MIX_WR;
      ST_MIX_WR: begin
        lane_we = 1'b1;
        if (lane_cnt == LC_W'(MAX_HASH_FUNCS - 1)) begin
          if (!do_fin) begin
            state_next = ST_IDLE;
          end else begin
            state_next = (n_hash == '0) ? ST_IDLE : ST_FIN_RD;
          end
        end else begin
          state_next = ST_MIX_RD;
        end
      end
      ST_FIN_RD: state_next = ST_FIN_M1;
      ST_FIN_M1: state_next = ST_FIN_M2;
      ST_FIN_M2: begin
        rem_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (rem_done) state_next = ST_BYTE_RD;
      end
      ST_BYTE_RD: state_next = ST_BYTE_WR;
      ST_BYTE_WR: begin
        filt_we    = 1'b1;
        filt_wdata = filt_rdata | (8'd1 << rem_val[2:0]);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          state_next = (lane_cnt + LC_W'(1) == n_hash) ? ST_IDLE : ST_FIN_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tweak        <= 32'd0;
      hash_count   <= 6'd50;
      filter_bytes <= 16'd36000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TWEAK:        tweak        <= cfg_data;
        REG_HASH_COUNT:   hash_count   <= cfg_data[5:0];
        REG_FILTER_BYTES: filter_bytes <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= 32'd0;
      pend       <= 32'd0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      fresh      <= 1'b0;
      do_fin     <= 1'b0;
      tail_en    <= 1'b0;
      lane_cnt   <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + FA_W'(1);
        ST_IDLE: begin
          if (accept) begin
            if (key_length == 32'd0) begin
              tweak_lat <= tweak;
              fresh     <= 1'b1;
            end
            pend       <= pend_new;
            key_length <= key_length + 32'd1;
            do_fin     <= in_data.key_last;
            tail_en    <= (pos != 2'd3);
            lane_cnt   <= '0;
            seed_run   <= (key_length == 32'd0) ? tweak : tweak_lat;
          end
        end
        ST_SC1: acc <= prod;
        ST_SC2: begin
          kscr <= prod;
          if (tail_en && n_hash == '0) begin
            key_length <= 32'd0;
            pend       <= 32'd0;
          end
        end
        ST_MIX_WR: begin
          pend <= 32'd0;
          if (lane_cnt == LC_W'(MAX_HASH_FUNCS - 1)) begin
            fresh    <= 1'b0;
            lane_cnt <= '0;
            seed_run <= tweak_lat;
            tail_en  <= 1'b0;
            if (do_fin && n_hash == '0) key_length <= 32'd0;
          end else begin
            lane_cnt <= lane_cnt + LC_W'(1);
            seed_run <= seed_run + SEED_STEP;
          end
        end
        ST_FIN_M1: acc <= prod;
        ST_FIN_M2: acc <= prod;
        ST_BYTE_WR: new_byte <= filt_rdata | (8'd1 << rem_val[2:0]);
        ST_OUT: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_data.hash_number <= 6'(lane_cnt);
            out_data.bit_index   <= rem_val[18:0];
            out_data.filter_byte <= new_byte;
            out_data.last        <= (lane_cnt + LC_W'(1) == n_hash);
            lane_cnt             <= lane_cnt + LC_W'(1);
            seed_run             <= seed_run + SEED_STEP;
            if (lane_cnt + LC_W'(1) == n_hash) begin
              key_length <= 32'd0;
              pend       <= 32'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lane_we) lane_mem[lane_cnt[LA_W-1:0]] <= lane_wdata;
    lane_rdata <= lane_mem[lane_cnt[LA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (filt_we) filt_mem[filt_waddr] <= filt_wdata;
    filt_rdata <= filt_mem[byte_addr];
  end

  // the divider latches the last finalizer step straight from the multiplier
  bfm3_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (prod ^ (prod >> 16)),
    .modulus  (modulus),
    .done     (rem_done),
    .rem      (rem_val)
  );

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> rem_val < modulus)
    else $error("remainder not below modulus");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    accept && (pos == 2'd3 || in_data.key_last) |=> in_stall)
    else $error("block free right after a block or last beat");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    lane_cnt <= LC_W'(MAX_HASH_FUNCS))
    else $error("lane counter out of range");

  a_out_in_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && slot_free |=> out_valid && out_data.hash_number == 6'($past(lane_cnt)))
    else $error("result not loaded for current lane");

endmodule

// ===== dv/bloom_filter_murmur3_insert_test.sv =====
`timescale 1ns / 1ps
module bloom_filter_murmur3_insert_test;
  import bfm3_pkg::*;

  localparam int NFB = 36000;
  localparam int NHF = 50;
  localparam int WATCHDOG_LIMIT = 200000;

  class bloom_scoreboard;
    logic [31:0] tweak_r;
    logic [5:0]  hash_count_r;
    logic [15:0] filter_bytes_r;
    logic [7:0]  filter_mirror [NFB];
    logic [31:0] lane [NHF];
    logic [31:0] pend;
    logic [31:0] klen;
    out_item_t   pending_results [$];
    int          errors;

    function new();
      tweak_r = 0;
      hash_count_r = 50;
      filter_bytes_r = 16'd36000;
      foreach (filter_mirror[i]) filter_mirror[i] = 8'h00;
      pend = 0;
      klen = 0;
      errors = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] scramble(logic [31:0] k);
      k = k * MM_C1;
      k = rotl(k, 15);
      return k * MM_C2;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TWEAK: tweak_r = val;
        REG_HASH_COUNT: hash_count_r = val[5:0];
        REG_FILTER_BYTES: filter_bytes_r = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(in_item_t it);
      logic [31:0] k, h, modulus, idx, fb;
      int n;
      logic has_tail;
      if (klen == 0) begin
        for (int i = 0; i < NHF; i++) lane[i] = i * SEED_STEP + tweak_r;
        pend = 0;
      end
      pend = pend | (32'(it.key_byte) << (8 * klen[1:0]));
      if (klen[1:0] == 2'd3) begin
        k = scramble(pend);
        for (int i = 0; i < NHF; i++) begin
          h = rotl(lane[i] ^ k, 13);
          lane[i] = h * 5 + MM_ADD;
        end
        pend = 0;
      end
      klen = klen + 1;
      if (!it.key_last) return;
      n = (hash_count_r > NHF) ? NHF : hash_count_r;
      fb = filter_bytes_r;
      if (fb == 0) fb = 1;
      if (fb > NFB) fb = NFB;
      modulus = fb * 8;
      has_tail = klen[1:0] != 0;
      k = scramble(pend);
      for (int i = 0; i < n; i++) begin
        out_item_t r;
        h = lane[i];
        if (has_tail) h = h ^ k;
        h = h ^ klen;
        h = h ^ (h >> 16);
        h = h * MM_F1;
        h = h ^ (h >> 13);
        h = h * MM_F2;
        h = h ^ (h >> 16);
        idx = h % modulus;
        filter_mirror[idx >> 3] = filter_mirror[idx >> 3] | (8'd1 << idx[2:0]);
        r.hash_number = i[5:0];
        r.bit_index = idx[18:0];
        r.filter_byte = filter_mirror[idx >> 3];
        r.last = (i + 1 == n);
        pending_results.push_back(r);
      end
      klen = 0;
      pend = 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.hash_number !== exp_r.hash_number) begin
        $display("%0t: hash_number exp %0d got %0d", $time, exp_r.hash_number,
                 got.hash_number);
        errors++;
      end
      if (got.bit_index !== exp_r.bit_index) begin
        $display("%0t: bit_index exp %0d got %0d", $time, exp_r.bit_index, got.bit_index);
        errors++;
      end
      if (got.filter_byte !== exp_r.filter_byte) begin
        $display("%0t: filter_byte exp %h got %h", $time, exp_r.filter_byte,
                 got.filter_byte);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  bloom_scoreboard sb;
  int          idle_cycles = 0;
  logic        long_hold = 0;
  logic        feeding_done = 0;

  always #5 clk = ~clk;

  bloom_filter_murmur3_insert u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (long_hold) out_stall <= 1;
    else if (feeding_done) out_stall <= (r < 15);
    else out_stall <= (r < 30) && ((r % 3) != 0) && ($time % 4000 < 2500);
  end

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic l);
    in_valid <= 1;
    in_data <= '{key_byte: b, key_last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_random();
    int g;
    g = $urandom_range(0, 3);
    if (g == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_key(int len, logic [7:0] fill, logic rnd);
    for (int i = 0; i < len; i++) begin
      send_byte(rnd ? 8'($urandom) : fill, i == len - 1);
      pause_random();
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  initial begin
    int len;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: defaults, extremes of bytes and of configuration, short and tail lengths
    write_cfg(REG_HASH_COUNT, 32'd3);
    write_cfg(REG_FILTER_BYTES, 32'd1);
    send_key(1, 8'h00, 0);
    send_key(1, 8'hff, 0);
    send_key(4, 8'hff, 0);
    send_key(5, 8'ha5, 0);
    drain();
    write_cfg(REG_TWEAK, 32'hffffffff);
    write_cfg(REG_HASH_COUNT, 32'd0);
    write_cfg(REG_FILTER_BYTES, 32'd0);
    send_key(3, 8'h5a, 0);
    drain();
    write_cfg(REG_HASH_COUNT, 32'd63);
    write_cfg(REG_FILTER_BYTES, 32'hffff);
    send_key(2, 8'h01, 0);
    drain();
    write_cfg(REG_HASH_COUNT, 32'd50);
    write_cfg(REG_FILTER_BYTES, 32'd36000);
    write_cfg(REG_TWEAK, 32'h0);
    send_key(7, 8'h00, 1);
    drain();
    // long receiver hold while the sender keeps offering
    write_cfg(REG_HASH_COUNT, 32'd4);
    write_cfg(REG_FILTER_BYTES, 32'd64);
    fork
      begin
        long_hold = 1;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      begin
        for (int k = 0; k < 4; k++) send_key(2, 8'h00, 1);
        in_valid <= 0;
      end
    join
    drain();
    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_TWEAK, $urandom);
      write_cfg(REG_HASH_COUNT, (ph == 0) ? 32'd1 : $urandom_range(1, 8));
      write_cfg(REG_FILTER_BYTES, (ph == 1) ? 32'd36000 : $urandom_range(1, 200));
      for (int k = 0; k < 5; k++) begin
        len = $urandom_range(1, 9);
        send_key(len, 8'h00, 1);
        if ($urandom_range(0, 2) == 0) begin
          in_valid <= 0;
          repeat ($urandom_range(5, 40)) @(posedge clk);
        end
      end
      drain();
    end
    feeding_done = 1;
    in_valid <= 0;
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
